FILE: rtl/rfc_pkg.sv
// Shared widths, register indexes and pipeline stage taps for the cylinder side-hit block.
package rfc_pkg;

    localparam int DAT_W   = 32;   // Q16.16 coordinate width
    localparam int AX_W    = 18;   // axis component width
    localparam int LEN_W   = 31;   // radius and height width
    localparam int FRAC    = 16;   // fraction bits of Q16.16
    localparam int CFG_IDX_W = 3;

    localparam int CO_W    = 33;   // origin minus center
    localparam int P_W     = 52;   // d*u and co*u products
    localparam int DU_W    = 36;   // projections onto the axis
    localparam int M_W     = 54;   // u*du, u*cu
    localparam int DP_W    = 36;   // projected direction and offset
    localparam int PRD_W   = 72;   // dot product terms
    localparam int RR_W    = 62;   // radius squared
    localparam int ABC_W   = 56;   // a, hb, c
    localparam int MAG_W   = 56;   // magnitudes fed to the wide products
    localparam int HALF_W  = 28;   // half of a magnitude
    localparam int DISC_W  = 112;  // discriminant, Q80.32
    localparam int SQ_BITS = 56;   // root bits, one per stage
    localparam int NUM_W   = 58;   // -hb -/+ s
    localparam int DIV_W   = 90;   // divider remainder
    localparam int DIV_BITS = 31;  // quotient bits, one per stage
    localparam int PQ_W    = 64;   // d*t
    localparam int CQ_W    = 50;   // hit point minus center
    localparam int CW_W    = 68;   // (p - c)*u
    localparam int DIST_W  = 56;   // axial distance

    localparam logic signed [DAT_W-1:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DAT_W-1:0] T_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd7;

    // Pipeline taps: index of the register stage holding each step's result
    localparam int ST_S1     = 0;
    localparam int ST_S2     = 1;
    localparam int ST_S3     = 2;
    localparam int ST_S4     = 3;
    localparam int ST_S5     = 4;
    localparam int ST_S6     = 5;
    localparam int ST_S7     = 6;
    localparam int ST_S8     = 7;
    localparam int ST_S9     = 8;
    localparam int ST_S10    = 9;
    localparam int ST_SQ_END = ST_S10 + SQ_BITS;
    localparam int ST_D0     = ST_SQ_END + 1;
    localparam int ST_D1     = ST_D0 + 1;
    localparam int ST_DV_END = ST_D1 + DIV_BITS;
    localparam int ST_F      = ST_DV_END + 1;
    localparam int ST_C1     = ST_F + 1;
    localparam int ST_C2     = ST_C1 + 1;
    localparam int ST_C3     = ST_C2 + 1;
    localparam int ST_C4     = ST_C3 + 1;
    localparam int LAT       = ST_C4 + 1;

endpackage

FILE: rtl/ray_finite_cylinder_side_hit.sv
// Pipelined ray against finite cylinder side surface, one ray per cycle while the output is not held.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready    | origin_x/y/z, dir_x/y/z
//  out     | out       | out_valid/out_ready  | side_hit, t_near, t_far, near/far_in_caps
//
//  One item enters per cycle unless the output is held; results leave in the order their items were accepted.
//  Most of the pipeline depth is the 56-stage square root and the 31-stage dividers.
//  rst_n clears the valid bits and loads the cylinder registers with their defaults.
//  A held result at the output stalls the whole pipeline; in_ready drops with it.
module ray_finite_cylinder_side_hit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [31:0]       origin_x,
    input  logic signed [31:0]       origin_y,
    input  logic signed [31:0]       origin_z,
    input  logic signed [31:0]       dir_x,
    input  logic signed [31:0]       dir_y,
    input  logic signed [31:0]       dir_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     side_hit,
    output logic signed [31:0]       t_near,
    output logic signed [31:0]       t_far,
    output logic                     near_in_caps,
    output logic                     far_in_caps
);

    // ---------------- configuration ----------------
    logic signed [rfc_pkg::DAT_W-1:0] center_reg [3];
    logic signed [rfc_pkg::DAT_W-1:0] center_next [3];
    logic signed [rfc_pkg::AX_W-1:0]  axis_reg [3];
    logic signed [rfc_pkg::AX_W-1:0]  axis_next [3];
    logic [rfc_pkg::LEN_W-1:0]        radius_reg, radius_next;
    logic [rfc_pkg::LEN_W-1:0]        height_reg, height_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        center_next = center_reg;
        axis_next   = axis_reg;
        radius_next = radius_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rfc_pkg::REG_CENTER_X: center_next[0] = cfg_data;
                rfc_pkg::REG_CENTER_Y: center_next[1] = cfg_data;
                rfc_pkg::REG_CENTER_Z: center_next[2] = cfg_data;
                rfc_pkg::REG_AXIS_X:   axis_next[0]   = cfg_data[rfc_pkg::AX_W-1:0];
                rfc_pkg::REG_AXIS_Y:   axis_next[1]   = cfg_data[rfc_pkg::AX_W-1:0];
                rfc_pkg::REG_AXIS_Z:   axis_next[2]   = cfg_data[rfc_pkg::AX_W-1:0];
                rfc_pkg::REG_RADIUS:   radius_next    = cfg_data[rfc_pkg::LEN_W-1:0];
                rfc_pkg::REG_HEIGHT:   height_next    = cfg_data[rfc_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '{default: '0};
            axis_reg   <= '{18'sd0, 18'sd65536, 18'sd0};
            radius_reg <= 31'd65536;
            height_reg <= 31'd131072;
        end
        else
        begin
            center_reg <= center_next;
            axis_reg   <= axis_next;
            radius_reg <= radius_next;
            height_reg <= height_next;
        end
    end

    // ---------------- pipeline control ----------------
    logic                      en;
    logic [rfc_pkg::LAT-1:0]   vld_reg, vld_next;

    assign en        = !vld_reg[rfc_pkg::ST_C4] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[rfc_pkg::ST_C4];

    always_comb
    begin
        vld_next = vld_reg;
        if (en)
            vld_next = {vld_reg[rfc_pkg::LAT-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Ray rides alongside until the hit points are formed
    logic signed [rfc_pkg::DAT_W-1:0] o_in [3];
    logic signed [rfc_pkg::DAT_W-1:0] d_in [3];
    logic signed [rfc_pkg::DAT_W-1:0] ro_reg [rfc_pkg::ST_S1:rfc_pkg::ST_C1][3];
    logic signed [rfc_pkg::DAT_W-1:0] rd_reg [rfc_pkg::ST_S1:rfc_pkg::ST_C1][3];

    assign o_in = '{origin_x, origin_y, origin_z};
    assign d_in = '{dir_x, dir_y, dir_z};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ro_reg[rfc_pkg::ST_S1] <= o_in;
            rd_reg[rfc_pkg::ST_S1] <= d_in;
            for (int s = rfc_pkg::ST_S1 + 1; s <= rfc_pkg::ST_C1; s++)
            begin
                ro_reg[s] <= ro_reg[s-1];
                rd_reg[s] <= rd_reg[s-1];
            end
        end
    end

    // ---------------- S1: offset from center, axis products ----------------
    logic signed [rfc_pkg::CO_W-1:0] co_reg [3], co_next [3];
    logic signed [rfc_pkg::P_W-1:0]  pdu_reg [3], pdu_next [3];
    logic signed [rfc_pkg::P_W-1:0]  pcu_reg [3], pcu_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            co_next[i]  = rfc_pkg::CO_W'(o_in[i]) - rfc_pkg::CO_W'(center_reg[i]);
            pdu_next[i] = rfc_pkg::P_W'(d_in[i]) * rfc_pkg::P_W'(axis_reg[i]);
            pcu_next[i] = rfc_pkg::P_W'(co_next[i]) * rfc_pkg::P_W'(axis_reg[i]);
        end
    end

    // ---------------- S2: projections onto the axis ----------------
    logic signed [rfc_pkg::DU_W-1:0] du_reg, du_next, cu_reg, cu_next;
    logic signed [rfc_pkg::CO_W-1:0] co_s2_reg [3];

    always_comb
    begin
        du_next = rfc_pkg::DU_W'((pdu_reg[0] + pdu_reg[1] + pdu_reg[2]) >>> rfc_pkg::FRAC);
        cu_next = rfc_pkg::DU_W'((pcu_reg[0] + pcu_reg[1] + pcu_reg[2]) >>> rfc_pkg::FRAC);
    end

    // ---------------- S3: axis times projection ----------------
    logic signed [rfc_pkg::M_W-1:0]  md_reg [3], md_next [3];
    logic signed [rfc_pkg::M_W-1:0]  mc_reg [3], mc_next [3];
    logic signed [rfc_pkg::CO_W-1:0] co_s3_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            md_next[i] = rfc_pkg::M_W'(axis_reg[i]) * rfc_pkg::M_W'(du_reg);
            mc_next[i] = rfc_pkg::M_W'(axis_reg[i]) * rfc_pkg::M_W'(cu_reg);
        end
    end

    // ---------------- S4: remove the axial part ----------------
    logic signed [rfc_pkg::DP_W-1:0] dp_reg [3], dp_next [3];
    logic signed [rfc_pkg::DP_W-1:0] cp_reg [3], cp_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dp_next[i] = rfc_pkg::DP_W'(rfc_pkg::M_W'(rd_reg[rfc_pkg::ST_S3][i])
                         - (md_reg[i] >>> rfc_pkg::FRAC));
            cp_next[i] = rfc_pkg::DP_W'(rfc_pkg::M_W'(co_s3_reg[i])
                         - (mc_reg[i] >>> rfc_pkg::FRAC));
        end
    end

    // ---------------- S5: quadratic terms ----------------
    logic signed [rfc_pkg::PRD_W-1:0] paa_reg [3], paa_next [3];
    logic signed [rfc_pkg::PRD_W-1:0] pab_reg [3], pab_next [3];
    logic signed [rfc_pkg::PRD_W-1:0] pcc_reg [3], pcc_next [3];
    logic [rfc_pkg::RR_W-1:0]         rr_reg, rr_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            paa_next[i] = rfc_pkg::PRD_W'(dp_reg[i]) * rfc_pkg::PRD_W'(dp_reg[i]);
            pab_next[i] = rfc_pkg::PRD_W'(dp_reg[i]) * rfc_pkg::PRD_W'(cp_reg[i]);
            pcc_next[i] = rfc_pkg::PRD_W'(cp_reg[i]) * rfc_pkg::PRD_W'(cp_reg[i]);
        end
        rr_next = rfc_pkg::RR_W'(radius_reg) * rfc_pkg::RR_W'(radius_reg);
    end

    // ---------------- S6: a, half b, c ----------------
    logic signed [rfc_pkg::ABC_W-1:0] a_reg, a_next, hb_reg, hb_next, cc_reg, cc_next;

    always_comb
    begin
        a_next  = rfc_pkg::ABC_W'(paa_reg[0] >>> rfc_pkg::FRAC)
                + rfc_pkg::ABC_W'(paa_reg[1] >>> rfc_pkg::FRAC)
                + rfc_pkg::ABC_W'(paa_reg[2] >>> rfc_pkg::FRAC);
        hb_next = rfc_pkg::ABC_W'(pab_reg[0] >>> rfc_pkg::FRAC)
                + rfc_pkg::ABC_W'(pab_reg[1] >>> rfc_pkg::FRAC)
                + rfc_pkg::ABC_W'(pab_reg[2] >>> rfc_pkg::FRAC);
        cc_next = rfc_pkg::ABC_W'(pcc_reg[0] >>> rfc_pkg::FRAC)
                + rfc_pkg::ABC_W'(pcc_reg[1] >>> rfc_pkg::FRAC)
                + rfc_pkg::ABC_W'(pcc_reg[2] >>> rfc_pkg::FRAC)
                - $signed(rfc_pkg::ABC_W'(rr_reg >> rfc_pkg::FRAC));
    end

    // ---------------- S7: magnitudes ----------------
    logic [rfc_pkg::MAG_W-1:0] hbm_reg, hbm_next, ccm_reg, ccm_next, am_reg, am_next;
    logic signed [rfc_pkg::ABC_W-1:0] hb_l_reg [rfc_pkg::ST_S7:rfc_pkg::ST_SQ_END];
    logic [rfc_pkg::MAG_W-1:0]        a_l_reg  [rfc_pkg::ST_S7:rfc_pkg::ST_DV_END];
    logic                             cle_reg  [rfc_pkg::ST_S7:rfc_pkg::ST_S9];
    logic                             anz_reg  [rfc_pkg::ST_S7:rfc_pkg::ST_S9];

    always_comb
    begin
        hbm_next = hb_reg[rfc_pkg::ABC_W-1] ? rfc_pkg::MAG_W'(-hb_reg)
                                            : rfc_pkg::MAG_W'(hb_reg);
        ccm_next = cc_reg[rfc_pkg::ABC_W-1] ? rfc_pkg::MAG_W'(-cc_reg)
                                            : rfc_pkg::MAG_W'(cc_reg);
        am_next  = rfc_pkg::MAG_W'(a_reg);
    end

    // ---------------- S8: partial products of hb*hb and a*|c| ----------------
    localparam int PP_W = 2 * rfc_pkg::HALF_W;
    logic [PP_W-1:0] hb_ll_reg, hb_lh_reg, hb_hh_reg;
    logic [PP_W-1:0] ac_ll_reg, ac_lh_reg, ac_hl_reg, ac_hh_reg;
    logic [PP_W-1:0] hb_ll_next, hb_lh_next, hb_hh_next;
    logic [PP_W-1:0] ac_ll_next, ac_lh_next, ac_hl_next, ac_hh_next;
    logic [rfc_pkg::HALF_W-1:0] hbl, hbh, aml, amh, ccl, cch;

    always_comb
    begin
        hbl = hbm_reg[rfc_pkg::HALF_W-1:0];
        hbh = hbm_reg[rfc_pkg::MAG_W-1:rfc_pkg::HALF_W];
        aml = am_reg[rfc_pkg::HALF_W-1:0];
        amh = am_reg[rfc_pkg::MAG_W-1:rfc_pkg::HALF_W];
        ccl = ccm_reg[rfc_pkg::HALF_W-1:0];
        cch = ccm_reg[rfc_pkg::MAG_W-1:rfc_pkg::HALF_W];
        hb_ll_next = PP_W'(hbl) * PP_W'(hbl);
        hb_lh_next = PP_W'(hbl) * PP_W'(hbh);
        hb_hh_next = PP_W'(hbh) * PP_W'(hbh);
        ac_ll_next = PP_W'(aml) * PP_W'(ccl);
        ac_lh_next = PP_W'(aml) * PP_W'(cch);
        ac_hl_next = PP_W'(amh) * PP_W'(ccl);
        ac_hh_next = PP_W'(amh) * PP_W'(cch);
    end

    // ---------------- S9: assemble the wide products ----------------
    logic [rfc_pkg::DISC_W-1:0] hb2_reg, hb2_next, ac_reg, ac_next;

    always_comb
    begin
        hb2_next = (rfc_pkg::DISC_W'(hb_hh_reg) << PP_W)
                 + (rfc_pkg::DISC_W'(hb_lh_reg) << (rfc_pkg::HALF_W + 1))
                 + rfc_pkg::DISC_W'(hb_ll_reg);
        ac_next  = (rfc_pkg::DISC_W'(ac_hh_reg) << PP_W)
                 + ((rfc_pkg::DISC_W'(ac_lh_reg) + rfc_pkg::DISC_W'(ac_hl_reg))
                    << rfc_pkg::HALF_W)
                 + rfc_pkg::DISC_W'(ac_ll_reg);
    end

    // ---------------- S10: discriminant ----------------
    logic [rfc_pkg::DISC_W-1:0] disc_next;
    logic                       hit_next;
    logic [rfc_pkg::DISC_W-1:0] sq_rem_reg [rfc_pkg::ST_S10:rfc_pkg::ST_SQ_END];
    logic [rfc_pkg::SQ_BITS-1:0] sq_res_reg [rfc_pkg::ST_S10:rfc_pkg::ST_SQ_END];
    logic                       hit_reg [rfc_pkg::ST_S10:rfc_pkg::ST_C3];

    always_comb
    begin
        hit_next  = anz_reg[rfc_pkg::ST_S9];
        disc_next = hb2_reg;
        if (cle_reg[rfc_pkg::ST_S9])
            disc_next = hb2_reg + ac_reg;
        else if (ac_reg <= hb2_reg)
            disc_next = hb2_reg - ac_reg;
        else
            hit_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            co_reg  <= co_next;
            pdu_reg <= pdu_next;
            pcu_reg <= pcu_next;

            du_reg    <= du_next;
            cu_reg    <= cu_next;
            co_s2_reg <= co_reg;

            md_reg    <= md_next;
            mc_reg    <= mc_next;
            co_s3_reg <= co_s2_reg;

            dp_reg <= dp_next;
            cp_reg <= cp_next;

            paa_reg <= paa_next;
            pab_reg <= pab_next;
            pcc_reg <= pcc_next;
            rr_reg  <= rr_next;

            a_reg  <= a_next;
            hb_reg <= hb_next;
            cc_reg <= cc_next;

            hbm_reg <= hbm_next;
            ccm_reg <= ccm_next;
            am_reg  <= am_next;
            hb_l_reg[rfc_pkg::ST_S7] <= hb_reg;
            a_l_reg[rfc_pkg::ST_S7]  <= am_next;
            cle_reg[rfc_pkg::ST_S7]  <= (cc_reg <= 0);
            anz_reg[rfc_pkg::ST_S7]  <= (a_reg != 0);
            for (int s = rfc_pkg::ST_S7 + 1; s <= rfc_pkg::ST_SQ_END; s++)
                hb_l_reg[s] <= hb_l_reg[s-1];
            for (int s = rfc_pkg::ST_S7 + 1; s <= rfc_pkg::ST_DV_END; s++)
                a_l_reg[s] <= a_l_reg[s-1];
            for (int s = rfc_pkg::ST_S7 + 1; s <= rfc_pkg::ST_S9; s++)
            begin
                cle_reg[s] <= cle_reg[s-1];
                anz_reg[s] <= anz_reg[s-1];
            end

            hb_ll_reg <= hb_ll_next;
            hb_lh_reg <= hb_lh_next;
            hb_hh_reg <= hb_hh_next;
            ac_ll_reg <= ac_ll_next;
            ac_lh_reg <= ac_lh_next;
            ac_hl_reg <= ac_hl_next;
            ac_hh_reg <= ac_hh_next;

            hb2_reg <= hb2_next;
            ac_reg  <= ac_next;

            sq_rem_reg[rfc_pkg::ST_S10] <= disc_next;
            sq_res_reg[rfc_pkg::ST_S10] <= '0;
            hit_reg[rfc_pkg::ST_S10]    <= hit_next;
            for (int s = rfc_pkg::ST_S10 + 1; s <= rfc_pkg::ST_C3; s++)
                hit_reg[s] <= hit_reg[s-1];
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    for (genvar j = 0; j < rfc_pkg::SQ_BITS; j++)
    begin : g_sqrt
        localparam int K  = rfc_pkg::SQ_BITS - 1 - j;
        localparam int SI = rfc_pkg::ST_S10 + j;
        logic [rfc_pkg::DISC_W-1:0]  trial;
        logic [rfc_pkg::DISC_W-1:0]  rem_next;
        logic [rfc_pkg::SQ_BITS-1:0] res_next;

        always_comb
        begin
            // (res + 2^K)^2 - res^2 = res*2^(K+1) + 2^(2K)
            trial    = (rfc_pkg::DISC_W'(sq_res_reg[SI]) << (K + 1))
                     | (rfc_pkg::DISC_W'(1) << (2 * K));
            rem_next = sq_rem_reg[SI];
            res_next = sq_res_reg[SI];
            if (sq_rem_reg[SI] >= trial)
            begin
                rem_next = sq_rem_reg[SI] - trial;
                res_next[K] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[SI+1] <= rem_next;
                sq_res_reg[SI+1] <= res_next;
            end
        end
    end

    // ---------------- D0, D1: numerators, sign, saturation ----------------
    logic signed [rfc_pkg::NUM_W-1:0] num_reg [2], num_next [2];
    logic [rfc_pkg::DIV_W-1:0]    dv_rem_reg [rfc_pkg::ST_D1:rfc_pkg::ST_DV_END][2];
    logic [rfc_pkg::DIV_BITS-1:0] dv_q_reg   [rfc_pkg::ST_D1:rfc_pkg::ST_DV_END][2];
    logic                         neg_reg    [rfc_pkg::ST_D1:rfc_pkg::ST_DV_END][2];
    logic                         sat_reg    [rfc_pkg::ST_D1:rfc_pkg::ST_DV_END][2];
    logic [rfc_pkg::DIV_W-1:0]    d1_rem_next [2];
    logic                         d1_neg_next [2];
    logic                         d1_sat_next [2];
    logic signed [rfc_pkg::NUM_W-1:0] sroot;
    logic [rfc_pkg::NUM_W-1:0]    d1_mag;

    always_comb
    begin
        sroot = $signed(rfc_pkg::NUM_W'(sq_res_reg[rfc_pkg::ST_SQ_END]));
        num_next[0] = -rfc_pkg::NUM_W'(hb_l_reg[rfc_pkg::ST_SQ_END]) - sroot;
        num_next[1] = -rfc_pkg::NUM_W'(hb_l_reg[rfc_pkg::ST_SQ_END]) + sroot;
    end

    always_comb
    begin
        d1_mag = '0;
        for (int k = 0; k < 2; k++)
        begin
            d1_neg_next[k] = num_reg[k][rfc_pkg::NUM_W-1];
            d1_mag         = d1_neg_next[k] ? rfc_pkg::NUM_W'(-num_reg[k])
                                            : rfc_pkg::NUM_W'(num_reg[k]);
            d1_rem_next[k] = rfc_pkg::DIV_W'(d1_mag) << rfc_pkg::FRAC;
            // quotient of 2^31 or more does not fit the result
            d1_sat_next[k] = d1_rem_next[k]
                >= (rfc_pkg::DIV_W'(a_l_reg[rfc_pkg::ST_D0]) << rfc_pkg::DIV_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            for (int k = 0; k < 2; k++)
            begin
                dv_rem_reg[rfc_pkg::ST_D1][k] <= d1_rem_next[k];
                dv_q_reg[rfc_pkg::ST_D1][k]   <= '0;
                neg_reg[rfc_pkg::ST_D1][k]    <= d1_neg_next[k];
                sat_reg[rfc_pkg::ST_D1][k]    <= d1_sat_next[k];
            end
            for (int s = rfc_pkg::ST_D1 + 1; s <= rfc_pkg::ST_DV_END; s++)
            begin
                neg_reg[s] <= neg_reg[s-1];
                sat_reg[s] <= sat_reg[s-1];
            end
        end
    end

    // ---------------- restoring divide, one quotient bit per stage ----------------
    for (genvar j = 0; j < rfc_pkg::DIV_BITS; j++)
    begin : g_div
        localparam int K  = rfc_pkg::DIV_BITS - 1 - j;
        localparam int SI = rfc_pkg::ST_D1 + j;
        logic [rfc_pkg::DIV_W-1:0]    trial;
        logic [rfc_pkg::DIV_W-1:0]    rem_next [2];
        logic [rfc_pkg::DIV_BITS-1:0] q_next [2];

        always_comb
        begin
            trial = rfc_pkg::DIV_W'(a_l_reg[SI]) << K;
            for (int k = 0; k < 2; k++)
            begin
                rem_next[k] = dv_rem_reg[SI][k];
                q_next[k]   = dv_q_reg[SI][k];
                if (dv_rem_reg[SI][k] >= trial)
                begin
                    rem_next[k] = dv_rem_reg[SI][k] - trial;
                    q_next[k][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[SI+1] <= rem_next;
                dv_q_reg[SI+1]   <= q_next;
            end
        end
    end

    // ---------------- F: signed, saturated distances ----------------
    logic signed [rfc_pkg::DAT_W-1:0] t_reg [rfc_pkg::ST_F:rfc_pkg::ST_C3][2];
    logic signed [rfc_pkg::DAT_W-1:0] t_next [2];
    logic signed [rfc_pkg::DAT_W-1:0] qs;

    always_comb
    begin
        qs = '0;
        for (int k = 0; k < 2; k++)
        begin
            qs = $signed(rfc_pkg::DAT_W'(dv_q_reg[rfc_pkg::ST_DV_END][k]));
            if (sat_reg[rfc_pkg::ST_DV_END][k])
                t_next[k] = neg_reg[rfc_pkg::ST_DV_END][k] ? rfc_pkg::T_MIN : rfc_pkg::T_MAX;
            else
                t_next[k] = neg_reg[rfc_pkg::ST_DV_END][k] ? -qs : qs;
        end
    end

    // ---------------- C1..C4: axial distance of each hit point ----------------
    logic signed [rfc_pkg::PQ_W-1:0] pr_reg [2][3], pr_next [2][3];
    logic signed [rfc_pkg::CQ_W-1:0] cq_reg [2][3], cq_next [2][3];
    logic signed [rfc_pkg::CW_W-1:0] cw_reg [2][3], cw_next [2][3];
    logic signed [rfc_pkg::DIST_W-1:0] ax_sum;
    logic signed [rfc_pkg::DIST_W:0]   twice, hmax;
    logic                              caps_next [2];

    always_comb
    begin
        for (int k = 0; k < 2; k++)
            for (int i = 0; i < 3; i++)
            begin
                pr_next[k][i] = rfc_pkg::PQ_W'(rd_reg[rfc_pkg::ST_F][i])
                              * rfc_pkg::PQ_W'(t_reg[rfc_pkg::ST_F][k]);
                cq_next[k][i] = rfc_pkg::CQ_W'(ro_reg[rfc_pkg::ST_C1][i])
                              + rfc_pkg::CQ_W'(pr_reg[k][i] >>> rfc_pkg::FRAC)
                              - rfc_pkg::CQ_W'(center_reg[i]);
                cw_next[k][i] = rfc_pkg::CW_W'(cq_reg[k][i]) * rfc_pkg::CW_W'(axis_reg[i]);
            end
    end

    always_comb
    begin
        ax_sum = '0;
        twice  = '0;
        hmax   = $signed((rfc_pkg::DIST_W + 1)'(height_reg));
        for (int k = 0; k < 2; k++)
        begin
            ax_sum = rfc_pkg::DIST_W'(cw_reg[k][0] >>> rfc_pkg::FRAC)
                   + rfc_pkg::DIST_W'(cw_reg[k][1] >>> rfc_pkg::FRAC)
                   + rfc_pkg::DIST_W'(cw_reg[k][2] >>> rfc_pkg::FRAC);
            twice = (rfc_pkg::DIST_W + 1)'(ax_sum) <<< 1;
            caps_next[k] = (twice >= -hmax) && (twice <= hmax);
        end
    end

    // ---------------- output register ----------------
    logic                             hit_out_reg, hit_out_next;
    logic signed [rfc_pkg::DAT_W-1:0] tn_out_reg, tn_out_next, tf_out_reg, tf_out_next;
    logic                             nc_out_reg, nc_out_next, fc_out_reg, fc_out_next;

    always_comb
    begin
        // drop every field of a miss to zero
        hit_out_next = hit_reg[rfc_pkg::ST_C3];
        tn_out_next  = hit_out_next ? t_reg[rfc_pkg::ST_C3][0] : '0;
        tf_out_next  = hit_out_next ? t_reg[rfc_pkg::ST_C3][1] : '0;
        nc_out_next  = hit_out_next && caps_next[0];
        fc_out_next  = hit_out_next && caps_next[1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[rfc_pkg::ST_F] <= t_next;
            for (int s = rfc_pkg::ST_F + 1; s <= rfc_pkg::ST_C3; s++)
                t_reg[s] <= t_reg[s-1];
            pr_reg <= pr_next;
            cq_reg <= cq_next;
            cw_reg <= cw_next;
            hit_out_reg <= hit_out_next;
            tn_out_reg  <= tn_out_next;
            tf_out_reg  <= tf_out_next;
            nc_out_reg  <= nc_out_next;
            fc_out_reg  <= fc_out_next;
        end
    end

    assign side_hit     = hit_out_reg;
    assign t_near       = tn_out_reg;
    assign t_far        = tf_out_reg;
    assign near_in_caps = nc_out_reg;
    assign far_in_caps  = fc_out_reg;

`ifndef SYNTHESIS
    // A miss carries no distances and no cap flags
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !side_hit |-> t_near == 0 && t_far == 0 && !near_in_caps && !far_in_caps)
        else $error("miss result with nonzero fields");

    // Roots come out ordered
    a_root_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && side_hit |-> t_near <= t_far)
        else $error("t_near above t_far");

    // A stall freezes every stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the ray against finite cylinder side-hit pipeline.
`timescale 1ns / 100ps

module testbench;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
    } ray_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] tn;
        logic signed [31:0] tf;
        logic               ni;
        logic               fi;
    } hit_t;

    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] origin_x, origin_y, origin_z;
    logic signed [31:0] dir_x, dir_y, dir_z;
    logic out_valid;
    logic out_ready;
    logic side_hit;
    logic signed [31:0] t_near, t_far;
    logic near_in_caps, far_in_caps;

    ray_t  ray_queue [$];
    hit_t  hit_queue [$];
    ray_t  ray_on_bus;
    logic  ray_took;
    int    send_idle;
    int    recv_idle;
    int    errors;
    int    quiet_cycles;

    // cylinder as the bench sees it
    wide_t cyl_c [3];
    wide_t cyl_u [3];
    wide_t cyl_r;
    wide_t cyl_h;

    ray_finite_cylinder_side_hit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .side_hit(side_hit), .t_near(t_near), .t_far(t_far),
        .near_in_caps(near_in_caps), .far_in_caps(far_in_caps)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic wide_t qmul(wide_t x, wide_t y);
        return (x * y) >>> 16;
    endfunction

    // quotient num * 2^16 / den toward zero, clamped to 32 bit signed
    function automatic wide_t root_div(wide_t num, wide_t den);
        logic  neg;
        wide_t mag;
        wide_t q;
        neg = num < 0;
        mag = neg ? -num : num;
        if (mag / den >= 32768)
            return neg ? wide_t'(rfc_pkg::T_MIN) : wide_t'(rfc_pkg::T_MAX);
        q = (mag <<< 16) / den;
        return neg ? -q : q;
    endfunction

    function automatic logic within_caps(ray_t r, wide_t t);
        wide_t ax_sum;
        wide_t p;
        ax_sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            p = wide_t'(r.org[i]) + qmul(wide_t'(r.dir[i]), t);
            ax_sum += qmul(p - cyl_c[i], cyl_u[i]);
        end
        return (2 * ax_sum >= -cyl_h) && (2 * ax_sum <= cyl_h);
    endfunction

    function automatic hit_t side_hit_of(ray_t r);
        wide_t d [3], co [3], dp [3], cp [3];
        wide_t du, cu, a, hb, cc, disc, s, cand, t0, t1;
        hit_t  res;
        res = '{hit: 1'b0, tn: '0, tf: '0, ni: 1'b0, fi: 1'b0};
        du = 0; cu = 0; a = 0; hb = 0; cc = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i]  = wide_t'(r.dir[i]);
            co[i] = wide_t'(r.org[i]) - cyl_c[i];
            du += d[i] * cyl_u[i];
            cu += co[i] * cyl_u[i];
        end
        du = du >>> 16;
        cu = cu >>> 16;
        for (int i = 0; i < 3; i++)
        begin
            dp[i] = d[i] - qmul(cyl_u[i], du);
            cp[i] = co[i] - qmul(cyl_u[i], cu);
            a  += qmul(dp[i], dp[i]);
            hb += qmul(dp[i], cp[i]);
            cc += qmul(cp[i], cp[i]);
        end
        cc -= qmul(cyl_r, cyl_r);
        if (a != 0)
        begin
            disc = hb * hb - a * cc;
            if (disc >= 0)
            begin
                s = 0;
                for (int b = 61; b >= 0; b--)
                begin
                    cand = s | (wide_t'(1) <<< b);
                    if (cand * cand <= disc)
                        s = cand;
                end
                t0 = root_div(-hb - s, a);
                t1 = root_div(-hb + s, a);
                res.hit = 1'b1;
                res.tn  = t0[31:0];
                res.tf  = t1[31:0];
                res.ni  = within_caps(r, t0);
                res.fi  = within_caps(r, t1);
            end
        end
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver: present the next ray when the bus is free
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || ray_took))
        begin
            if (ray_queue.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                ray_on_bus = ray_queue.pop_front();
                origin_x <= ray_on_bus.org[0];
                origin_y <= ray_on_bus.org[1];
                origin_z <= ray_on_bus.org[2];
                dir_x    <= ray_on_bus.dir[0];
                dir_y    <= ray_on_bus.dir[1];
                dir_z    <= ray_on_bus.dir[2];
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // monitor: predict on accepted rays, check accepted results
    always @(posedge clk)
    begin
        hit_t want;
        ray_took <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            hit_queue.push_back(side_hit_of(ray_on_bus));
        if (rst_n && out_valid && out_ready)
        begin
            if (hit_queue.size() == 0)
                report("unexpected item", 0, 0);
            else
            begin
                want = hit_queue.pop_front();
                if (side_hit !== want.hit)
                    report("side_hit", side_hit, want.hit);
                if (t_near !== want.tn)
                    report("t_near", t_near, want.tn);
                if (t_far !== want.tf)
                    report("t_far", t_far, want.tf);
                if (near_in_caps !== want.ni)
                    report("near_in_caps", near_in_caps, want.ni);
                if (far_in_caps !== want.fi)
                    report("far_in_caps", far_in_caps, want.fi);
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rfc_pkg::REG_CENTER_X: cyl_c[0] = wide_t'($signed(data));
            rfc_pkg::REG_CENTER_Y: cyl_c[1] = wide_t'($signed(data));
            rfc_pkg::REG_CENTER_Z: cyl_c[2] = wide_t'($signed(data));
            rfc_pkg::REG_AXIS_X:   cyl_u[0] = wide_t'($signed(data[17:0]));
            rfc_pkg::REG_AXIS_Y:   cyl_u[1] = wide_t'($signed(data[17:0]));
            rfc_pkg::REG_AXIS_Z:   cyl_u[2] = wide_t'($signed(data[17:0]));
            rfc_pkg::REG_RADIUS:   cyl_r    = wide_t'($signed({1'b0, data[30:0]}));
            rfc_pkg::REG_HEIGHT:   cyl_h    = wide_t'($signed({1'b0, data[30:0]}));
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] axis_word(int sel);
        logic signed [17:0] v;
        case (sel)
            0: v = 18'sd65536;
            1: v = -18'sd65536;
            2: v = 18'sd0;
            default: v = 18'($signed($urandom_range(131072)) - 65536);
        endcase
        return {14'($urandom), v};
    endfunction

    function automatic logic [31:0] len_word(int sel);
        case (sel)
            0: return {1'($urandom_range(1)), 31'd0};
            1: return {1'($urandom_range(1)), 31'h7FFF_FFFF};
            default: return {1'($urandom_range(1)),
                             31'($urandom_range(32'h0008_0000, 32'h0000_4000))};
        endcase
    endfunction

    task automatic setup_cylinder(int k);
        for (int i = 0; i < 3; i++)
        begin
            case (k % 4)
                0: write_reg(3'(rfc_pkg::REG_CENTER_X + i),
                             32'($signed($urandom_range(8 << 16)) - (4 << 16)));
                1: write_reg(3'(rfc_pkg::REG_CENTER_X + i), 32'h7FFF_FFF0);
                2: write_reg(3'(rfc_pkg::REG_CENTER_X + i), 32'h8000_0010);
                default: write_reg(3'(rfc_pkg::REG_CENTER_X + i), $urandom);
            endcase
        end
        write_reg(rfc_pkg::REG_AXIS_X, axis_word((k % 2 == 0) ? (k % 3) : 3));
        write_reg(rfc_pkg::REG_AXIS_Y, axis_word((k + 1) % 4));
        write_reg(rfc_pkg::REG_AXIS_Z, axis_word((k + 2) % 4));
        write_reg(rfc_pkg::REG_RADIUS, len_word(k % 5 == 1 ? 0 : (k % 5 == 2 ? 1 : 2)));
        write_reg(rfc_pkg::REG_HEIGHT, len_word(k % 4 == 3 ? 0 : (k % 4 == 1 ? 1 : 2)));
    endtask

    function automatic ray_t make_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                                      logic signed [31:0] oz, logic signed [31:0] dx,
                                      logic signed [31:0] dy, logic signed [31:0] dz);
        ray_t r;
        r.org = '{ox, oy, oz};
        r.dir = '{dx, dy, dz};
        return r;
    endfunction

    function automatic ray_t random_ray();
        ray_t r;
        int   kind;
        int   scale;
        kind = $urandom_range(99);
        scale = $urandom_range(3) ? 19 : 26;
        for (int i = 0; i < 3; i++)
        begin
            if (kind < 70)
            begin
                r.org[i] = 32'(cyl_c[i]) + 32'($signed($urandom) >>> (31 - scale));
                r.dir[i] = 32'($signed($urandom) >>> (31 - 18));
            end
            else if (kind < 80)
            begin
                r.org[i] = 32'(cyl_c[i]) + 32'($signed($urandom) >>> 12);
                r.dir[i] = 32'(cyl_u[i] * ($urandom_range(4) + 1));
            end
            else
            begin
                r.org[i] = $urandom;
                r.dir[i] = $urandom;
            end
        end
        return r;
    endfunction

    task automatic drain();
        while (ray_queue.size() > 0 || in_valid || hit_queue.size() > 0)
            @(posedge clk);
        repeat (rfc_pkg::LAT + 10) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; out_ready = 1'b0;
        origin_x = '0; origin_y = '0; origin_z = '0;
        dir_x = '0; dir_y = '0; dir_z = '0;
        ray_took = 1'b0;
        errors = 0; quiet_cycles = 0;
        send_idle = 15; recv_idle = 82;
        cyl_c = '{0, 0, 0};
        cyl_u = '{0, 65536, 0};
        cyl_r = 65536;
        cyl_h = 131072;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset cylinder: unit radius along y, height 2
        ray_queue.push_back(make_ray(-4 << 16, 0, 0, 1 << 16, 0, 0));
        ray_queue.push_back(make_ray(4 << 16, 0, 0, 1 << 16, 0, 0));
        ray_queue.push_back(make_ray(-4 << 16, 0, 1 << 16, 1 << 16, 0, 0));
        ray_queue.push_back(make_ray(-4 << 16, 0, 5 << 16, 1 << 16, 0, 0));
        ray_queue.push_back(make_ray(0, 0, 0, 0, 1 << 16, 0));
        ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 0));
        ray_queue.push_back(make_ray(-4 << 16, 0, 0, 1, 0, 0));
        ray_queue.push_back(make_ray(-4 << 16, 3 << 16, 0, 1 << 16, 0, 0));
        ray_queue.push_back(make_ray(-4 << 16, 1 << 16, 0, 1 << 16, 0, 0));
        ray_queue.push_back(make_ray(0, 0, 0, 1 << 16, 1 << 16, 1 << 16));
        ray_queue.push_back(make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        ray_queue.push_back(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        ray_queue.push_back(make_ray(32'h8000_0000, 0, 32'h7FFF_FFFF,
                                     32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000));
        ray_queue.push_back(make_ray(-1, -1, -1, -1, -1, -1));
        ray_queue.push_back(make_ray(0, 0, 0, -(1 << 16), 0, 32'h0000_8000));
        drain();

        for (int k = 0; k < 11; k++)
        begin
            if (k == 4)
            begin
                send_idle = 82; recv_idle = 15;
            end
            if (k == 8)
            begin
                send_idle = 0; recv_idle = 0;
            end
            setup_cylinder(k);
            for (int n = 0; n < 45; n++)
                ray_queue.push_back(random_ray());
            drain();
        end

        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rfc_pkg.sv
rtl/ray_finite_cylinder_side_hit.sv
bench/testbench.sv
